@@ src/rsst_pkg.sv @@
// ----------------------------------------------------------------------------
// Range sum segment tree package
// Shared widths, operation codes and types of the range sum segment tree.
// ----------------------------------------------------------------------------
package rsst_pkg;

  localparam int SUM_W      = 42;
  localparam int VAL_W      = 32;
  localparam int POS_W      = 10;
  localparam int RANGE_W    = 11;
  localparam int DEF_LEAVES = 1024;

  localparam logic FUNC_SET   = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef logic signed [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic valid;
    sum_t total;
  } result_t;

  function automatic sum_t sext_value(input logic signed [VAL_W-1:0] v);
    return {{(SUM_W-VAL_W){v[VAL_W-1]}}, v};
  endfunction

endpackage

@@ src/rsst_node_ram.sv @@
// ----------------------------------------------------------------------------
// Node memory
// Simple dual-port node store: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rsst_node_ram #(
  parameter int LEAVES = rsst_pkg::DEF_LEAVES
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [$clog2(LEAVES):0] waddr,
  input  rsst_pkg::sum_t        wdata,
  input  logic [$clog2(LEAVES):0] raddr,
  output rsst_pkg::sum_t        rdata
);

  localparam int DEPTH = 2 * LEAVES;

  rsst_pkg::sum_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/rsst_engine.sv @@
// ----------------------------------------------------------------------------
// Tree engine
// Sequencer that clears the node memory, walks leaf-to-root updates and
// walks range queries level by level, accumulating node sums.
// ----------------------------------------------------------------------------
module rsst_engine #(
  parameter int LEAVES = rsst_pkg::DEF_LEAVES
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              busy,
  input  logic                              func,
  input  logic [rsst_pkg::POS_W-1:0]        position,
  input  logic signed [rsst_pkg::VAL_W-1:0] new_value,
  input  logic [rsst_pkg::RANGE_W-1:0]      range_start,
  input  logic [rsst_pkg::RANGE_W-1:0]      range_end,
  output rsst_pkg::result_t                 result,
  input  logic                              result_ready,
  output logic                              mem_we,
  output logic [$clog2(LEAVES):0]           mem_waddr,
  output rsst_pkg::sum_t                    mem_wdata,
  output logic [$clog2(LEAVES):0]           mem_raddr,
  input  rsst_pkg::sum_t                    mem_rdata
);

  localparam int LVL = $clog2(LEAVES);
  localparam int AW  = LVL + 1;
  localparam int IW  = LVL + 2;

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_SET_LEAF = 3'd2;
  localparam logic [2:0] S_SET_UP   = 3'd3;
  localparam logic [2:0] S_Q_LO     = 3'd4;
  localparam logic [2:0] S_Q_HI     = 3'd5;
  localparam logic [2:0] S_DONE     = 3'd6;

  logic [2:0]     state;
  logic [2:0]     state_next;
  logic [AW-1:0]  clr;
  logic [AW-1:0]  node;
  rsst_pkg::sum_t cur;
  logic [IW-1:0]  lo;
  logic [IW-1:0]  hi;
  rsst_pkg::sum_t acc;
  rsst_pkg::sum_t acc_next;
  logic           pend;

  logic           take;
  logic           pos_ok;
  logic [31:0]    end_c;
  logic [31:0]    start_c;
  logic [AW-1:0]  parent;
  rsst_pkg::sum_t up_sum;
  logic [IW-1:0]  hi_dec;

  assign take   = in_valid && (state == S_IDLE);
  assign busy   = (state != S_IDLE);
  assign pos_ok = (32'(position) < 32'(LEAVES));
  assign parent = node >> 1;
  assign up_sum = cur + mem_rdata;
  assign hi_dec = hi - IW'(hi[0]);
  assign acc_next = pend ? (acc + mem_rdata) : acc;

  assign result.valid = (state == S_DONE);
  assign result.total = acc;

  always_comb begin
    end_c   = (32'(range_end) > 32'(LEAVES)) ? 32'(LEAVES) : 32'(range_end);
    start_c = (32'(range_start) > 32'(LEAVES)) ? 32'(LEAVES) : 32'(range_start);
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = node;
    mem_wdata  = cur;
    mem_raddr  = node ^ AW'(1);
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr;
        mem_wdata = '0;
        if (clr == '1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (take) begin
          if (func == rsst_pkg::FUNC_QUERY) begin
            state_next = S_Q_LO;
          end else if (pos_ok) begin
            state_next = S_SET_LEAF;
          end
        end
      end
      S_SET_LEAF: begin
        mem_we     = 1'b1;
        state_next = S_SET_UP;
      end
      S_SET_UP: begin
        mem_we    = 1'b1;
        mem_waddr = parent;
        mem_wdata = up_sum;
        mem_raddr = parent ^ AW'(1);
        if (parent == AW'(1)) begin
          state_next = S_IDLE;
        end
      end
      S_Q_LO: begin
        mem_raddr = lo[AW-1:0];
        state_next = (lo < hi) ? S_Q_HI : S_DONE;
      end
      S_Q_HI: begin
        mem_raddr  = hi_dec[AW-1:0];
        state_next = S_Q_LO;
      end
      S_DONE: begin
        if (result_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_CLEAR: begin
          clr <= clr + AW'(1);
        end
        S_IDLE: begin
          pend <= 1'b0;
          if (take) begin
            node <= AW'(32'(position) + 32'(LEAVES));
            cur  <= rsst_pkg::sext_value(new_value);
            lo   <= IW'(start_c + 32'(LEAVES));
            hi   <= IW'(end_c + 32'(LEAVES));
            acc  <= '0;
          end
        end
        S_SET_UP: begin
          node <= parent;
          cur  <= up_sum;
        end
        S_Q_LO: begin
          acc <= acc_next;
          if (lo < hi) begin
            pend <= lo[0];
            lo   <= lo + IW'(lo[0]);
          end else begin
            pend <= 1'b0;
          end
        end
        S_Q_HI: begin
          acc  <= acc_next;
          pend <= hi[0];
          lo   <= lo >> 1;
          hi   <= hi_dec >> 1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ src/range_sum_segment_tree.sv @@
// ----------------------------------------------------------------------------
// Range sum segment tree
// Sum segment tree with point set and half-open range sum query.
// ----------------------------------------------------------------------------
//  Channel  Handshake              Payload
//  input    in_valid / in_stall    func, position, new_value, range_start,
//                                  range_end
//  output   out_valid / out_stall  range_total
//
// A set writes one node per tree level through the node memory port, from the
// leaf up to the root. A query makes two node reads per level, then hands the
// sum to the output register.
// After reset the node memory is cleared with in_stall high.
// A held result stalls only a later query at its last step.
// ----------------------------------------------------------------------------
module range_sum_segment_tree #(
  parameter int LEAVES = rsst_pkg::DEF_LEAVES
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              func,
  input  logic [rsst_pkg::POS_W-1:0]        position,
  input  logic signed [rsst_pkg::VAL_W-1:0] new_value,
  input  logic [rsst_pkg::RANGE_W-1:0]      range_start,
  input  logic [rsst_pkg::RANGE_W-1:0]      range_end,
  output logic                              out_valid,
  input  logic                              out_stall,
  output rsst_pkg::sum_t                    range_total
);

  localparam int AW = $clog2(LEAVES) + 1;

  rsst_pkg::result_t result;
  logic              result_ready;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  rsst_pkg::sum_t    mem_wdata;
  logic [AW-1:0]     mem_raddr;
  rsst_pkg::sum_t    mem_rdata;

  assign result_ready = !out_valid || !out_stall;

  rsst_engine #(
    .LEAVES(LEAVES)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .busy         (in_stall),
    .func         (func),
    .position     (position),
    .new_value    (new_value),
    .range_start  (range_start),
    .range_end    (range_end),
    .result       (result),
    .result_ready (result_ready),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  rsst_node_ram #(
    .LEAVES(LEAVES)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result.valid && result_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.valid && result_ready) begin
      range_total <= result.total;
    end
  end

endmodule

@@ src/rsst_checker.sv @@
// ----------------------------------------------------------------------------
// Range sum segment tree checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module rsst_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              func,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [rsst_pkg::SUM_W-1:0] range_total
);

  // A held output transaction keeps its sum.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(range_total))
    else $error("range_total changed while stalled");

  // The node memory is being cleared right after reset.
  a_clear_busy: assert property (@(posedge clk)
    rst |=> in_stall)
    else $error("input taken during clearing pass");

  // A set never produces a result.
  a_set_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && func == rsst_pkg::FUNC_SET |=> !$rose(out_valid))
    else $error("result appeared after a set");

  // A query keeps the engine busy in the following cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && func == rsst_pkg::FUNC_QUERY |=> in_stall)
    else $error("query not in progress");

  // Results come only out of a busy engine.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without work in progress");

endmodule

bind range_sum_segment_tree rsst_checker u_rsst_checker (.*);
